@@ rtl/plxd_pkg.sv @@
package plxd_pkg;

  localparam int unsigned MaxPayload = 64;
  localparam int unsigned IdxW       = $clog2(MaxPayload);
  localparam int unsigned LenW       = $clog2(MaxPayload + 1);

  localparam logic [7:0] PreambleByte = 8'hBC;
  localparam logic [7:0] XorSeed      = 8'hFF;
  localparam logic [LenW-1:0] CopyLimitReset = LenW'(MaxPayload);

  typedef enum logic [1:0] {
    StPayloadByte = 2'd0,
    StEmptyFrame  = 2'd1,
    StCheckError  = 2'd2,
    StLenTooLarge = 2'd3
  } status_e;

endpackage

@@ rtl/preamble_length_xor_deframer_top.sv @@
// preamble-synchronised, length-prefixed frame receiver with an xor check
//
// in channel (in_valid_i/in_ready_o, rx_byte_i): one received byte per word.
// the block drops bytes until the preamble 0xbc, then takes the command/flags
// byte, a 16-bit little-endian length and the payload, which it writes into a
// 64 x 8 payload ram, then the check byte (xor of 0xff and all frame bytes).
// out channel (out_valid_o/out_ready_i): on a good check the first
// min(copy_limit, length) payload bytes leave one word each; an empty
// delivery gives one status 1 word, a bad check one status 2 word and a
// length above 64 one status 3 word at the second length byte.
// cfg channel (cfg_valid_i/cfg_ready_o, cfg_copy_limit_i) sets copy_limit;
// always ready, write only while idle.
// throughput: header and payload bytes are taken one per cycle while the
// output register is free; a single-word result appears in the output
// register the cycle after its byte. a good check starts a drain from the
// payload ram: one read per cycle into the ram read register, then the
// output register, the rest following one per cycle; no byte is taken
// during the drain. a stalled receiver holds the output register, which
// stops further bytes and the ram reads. reset returns to hunting with
// copy_limit 64; the ram is not cleared: only current-frame entries are read.
module preamble_length_xor_deframer_top
  import plxd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      rx_byte_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      status_o,
  output logic [3:0]      command_o,
  output logic [3:0]      frame_flags_o,
  output logic [7:0]      data_byte_o,
  output logic [6:0]      delivered_len_o,
  output logic            last_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [6:0]      cfg_copy_limit_i
);

  typedef enum logic [2:0] {
    PhHunt,
    PhHdr1,
    PhLenLo,
    PhLenHi,
    PhPayload,
    PhCheck,
    PhDrain
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [7:0]      xor_q, xor_d;
  logic [7:0]      hdr_q, hdr_d;
  logic [7:0]      len_lo_q, len_lo_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] seen_q, seen_d;
  logic [LenW-1:0] dlen_q, dlen_d;
  logic [LenW-1:0] rd_cnt_q, rd_cnt_d;
  logic [LenW-1:0] ld_cnt_q, ld_cnt_d;
  logic            rdata_vld_q, rdata_vld_d;
  logic [6:0]      copy_limit_q, copy_limit_d;

  logic            out_valid_q, out_valid_d;
  status_e         status_q, status_d;
  logic [7:0]      out_hdr_q, out_hdr_d;
  logic [7:0]      data_q, data_d;
  logic [6:0]      out_dlen_q, out_dlen_d;
  logic            last_q, last_d;

  logic [7:0]      mem_q [MaxPayload];
  logic [7:0]      rdata_q;

  logic            in_fire, out_free, wr_en, rd_en, ld_fire, ld_last;
  logic [15:0]     full_len;
  logic [6:0]      dlen_calc;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (phase_q != PhDrain) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign full_len  = {rx_byte_i, len_lo_q};
  assign dlen_calc = (7'(len_q) > copy_limit_q) ? copy_limit_q : 7'(len_q);

  assign wr_en   = in_fire && (phase_q == PhPayload);
  assign ld_fire = (phase_q == PhDrain) && rdata_vld_q && out_free;
  assign ld_last = (ld_cnt_q + LenW'(1)) == dlen_q;
  assign rd_en   = (phase_q == PhDrain) && (rd_cnt_q < dlen_q) &&
                   (!rdata_vld_q || ld_fire);

  // payload ram, synchronous read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[seen_q[IdxW-1:0]] <= rx_byte_i;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_cnt_q[IdxW-1:0]];
    end
  end

  always_comb begin
    phase_d      = phase_q;
    xor_d        = xor_q;
    hdr_d        = hdr_q;
    len_lo_d     = len_lo_q;
    len_d        = len_q;
    seen_d       = seen_q;
    dlen_d       = dlen_q;
    rd_cnt_d     = rd_cnt_q;
    ld_cnt_d     = ld_cnt_q;
    rdata_vld_d  = rdata_vld_q;
    copy_limit_d = copy_limit_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    out_hdr_d    = out_hdr_q;
    data_d       = data_q;
    out_dlen_d   = out_dlen_q;
    last_d       = last_q;

    if (cfg_valid_i) begin
      copy_limit_d = cfg_copy_limit_i;
    end

    if (in_fire) begin
      case (phase_q)
        PhHunt: begin
          if (rx_byte_i == PreambleByte) begin
            xor_d   = XorSeed ^ PreambleByte;
            phase_d = PhHdr1;
          end
        end
        PhHdr1: begin
          hdr_d   = rx_byte_i;
          xor_d   = xor_q ^ rx_byte_i;
          phase_d = PhLenLo;
        end
        PhLenLo: begin
          len_lo_d = rx_byte_i;
          xor_d    = xor_q ^ rx_byte_i;
          phase_d  = PhLenHi;
        end
        PhLenHi: begin
          xor_d  = xor_q ^ rx_byte_i;
          seen_d = '0;
          len_d  = LenW'(full_len);
          if (full_len > 16'(MaxPayload)) begin
            out_valid_d = 1'b1;
            status_d    = StLenTooLarge;
            out_hdr_d   = hdr_q;
            data_d      = '0;
            out_dlen_d  = '0;
            last_d      = 1'b1;
            phase_d     = PhHunt;
          end else if (full_len == 16'd0) begin
            phase_d = PhCheck;
          end else begin
            phase_d = PhPayload;
          end
        end
        PhPayload: begin
          xor_d  = xor_q ^ rx_byte_i;
          seen_d = seen_q + LenW'(1);
          if ((seen_q + LenW'(1)) >= len_q) begin
            phase_d = PhCheck;
          end
        end
        PhCheck: begin
          phase_d = PhHunt;
          if (rx_byte_i != xor_q) begin
            out_valid_d = 1'b1;
            status_d    = StCheckError;
            out_hdr_d   = hdr_q;
            data_d      = '0;
            out_dlen_d  = '0;
            last_d      = 1'b1;
          end else if (dlen_calc == 7'd0) begin
            out_valid_d = 1'b1;
            status_d    = StEmptyFrame;
            out_hdr_d   = hdr_q;
            data_d      = '0;
            out_dlen_d  = '0;
            last_d      = 1'b1;
          end else begin
            dlen_d      = LenW'(dlen_calc);
            rd_cnt_d    = '0;
            ld_cnt_d    = '0;
            rdata_vld_d = 1'b0;
            phase_d     = PhDrain;
          end
        end
        default: begin
          phase_d = PhHunt;
        end
      endcase
    end

    // drain: the registered ram read data feeds the output register
    if (phase_q == PhDrain) begin
      if (rd_en) begin
        rd_cnt_d    = rd_cnt_q + LenW'(1);
        rdata_vld_d = 1'b1;
      end else if (ld_fire) begin
        rdata_vld_d = 1'b0;
      end
      if (ld_fire) begin
        out_valid_d = 1'b1;
        status_d    = StPayloadByte;
        out_hdr_d   = hdr_q;
        data_d      = rdata_q;
        out_dlen_d  = 7'(dlen_q);
        last_d      = ld_last;
        ld_cnt_d    = ld_cnt_q + LenW'(1);
        if (ld_last) begin
          phase_d = PhHunt;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHunt;
      xor_q        <= XorSeed;
      hdr_q        <= '0;
      len_lo_q     <= '0;
      len_q        <= '0;
      seen_q       <= '0;
      dlen_q       <= '0;
      rd_cnt_q     <= '0;
      ld_cnt_q     <= '0;
      rdata_vld_q  <= 1'b0;
      copy_limit_q <= 7'(CopyLimitReset);
      out_valid_q  <= 1'b0;
      status_q     <= StPayloadByte;
      out_hdr_q    <= '0;
      data_q       <= '0;
      out_dlen_q   <= '0;
      last_q       <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      xor_q        <= xor_d;
      hdr_q        <= hdr_d;
      len_lo_q     <= len_lo_d;
      len_q        <= len_d;
      seen_q       <= seen_d;
      dlen_q       <= dlen_d;
      rd_cnt_q     <= rd_cnt_d;
      ld_cnt_q     <= ld_cnt_d;
      rdata_vld_q  <= rdata_vld_d;
      copy_limit_q <= copy_limit_d;
      out_valid_q  <= out_valid_d;
      status_q     <= status_d;
      out_hdr_q    <= out_hdr_d;
      data_q       <= data_d;
      out_dlen_q   <= out_dlen_d;
      last_q       <= last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign command_o       = out_hdr_q[3:0];
  assign frame_flags_o   = out_hdr_q[7:4];
  assign data_byte_o     = data_q;
  assign delivered_len_o = out_dlen_q;
  assign last_o          = last_q;

endmodule

@@ tb/preamble_length_xor_deframer_top_test.sv @@
`timescale 1ns / 1ps

import plxd_pkg::*;

typedef struct packed {
  status_e    status;
  logic [3:0] command;
  logic [3:0] flags;
  logic [7:0] data;
  logic [6:0] dlen;
  logic       last;
} deframe_word_t;

class deframe_scoreboard;
  typedef enum {Hunt, HeaderByte, LenLow, LenHigh, Payload, CheckByte} rx_phase_e;

  deframe_word_t expected_q[$];
  int unsigned   errors;
  logic [6:0]    copy_limit;
  rx_phase_e     phase;
  logic [7:0]    running_xor;
  logic [7:0]    header;
  logic [15:0]   frame_len;
  logic [15:0]   bytes_seen;
  logic [7:0]    payload [MaxPayload];

  function new();
    errors      = 0;
    copy_limit  = CopyLimitReset;
    phase       = Hunt;
    running_xor = XorSeed;
    header      = 8'h00;
    frame_len   = 16'h0000;
    bytes_seen  = 16'h0000;
  endfunction

  function void push_word(status_e st, logic [7:0] d, logic [6:0] n, logic l);
    deframe_word_t w;
    w.status  = st;
    w.command = header[3:0];
    w.flags   = header[7:4];
    w.data    = d;
    w.dlen    = n;
    w.last    = l;
    expected_q.push_back(w);
  endfunction

  // follows one accepted byte through the frame parser
  function void note_byte(logic [7:0] b);
    int unsigned n;
    int unsigned i;
    case (phase)
      HeaderByte: begin
        header = b;
        running_xor ^= b;
        phase = LenLow;
      end
      LenLow: begin
        frame_len = {8'h00, b};
        running_xor ^= b;
        phase = LenHigh;
      end
      LenHigh: begin
        frame_len[15:8] = b;
        running_xor ^= b;
        bytes_seen = 16'h0000;
        if (frame_len > MaxPayload) begin
          push_word(StLenTooLarge, 8'h00, 7'd0, 1'b1);
          phase = Hunt;
        end else if (frame_len == 0) begin
          phase = CheckByte;
        end else begin
          phase = Payload;
        end
      end
      Payload: begin
        if (bytes_seen < MaxPayload) payload[bytes_seen[5:0]] = b;
        bytes_seen++;
        running_xor ^= b;
        if (bytes_seen >= frame_len) phase = CheckByte;
      end
      CheckByte: begin
        if (b != running_xor) begin
          push_word(StCheckError, 8'h00, 7'd0, 1'b1);
        end else begin
          n = frame_len;
          if (n > copy_limit) n = copy_limit;
          if (n > MaxPayload) n = MaxPayload;
          if (n == 0) begin
            push_word(StEmptyFrame, 8'h00, 7'd0, 1'b1);
          end else begin
            for (i = 0; i < n; i++) push_word(StPayloadByte, payload[i], 7'(n), i + 1 == n);
          end
        end
        phase = Hunt;
      end
      default: begin
        if (b == PreambleByte) begin
          running_xor = XorSeed ^ PreambleByte;
          phase = HeaderByte;
        end
      end
    endcase
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  task report(string what);
    if (errors < 40) $display("%0t mismatch: %s", $time, what);
    errors++;
  endtask

  task check_word(deframe_word_t got);
    deframe_word_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected word, status %0d data %02h", got.status, got.data));
      return;
    end
    want = expected_q.pop_front();
    if (got.status !== want.status)
      report($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.command !== want.command)
      report($sformatf("command %h, want %h", got.command, want.command));
    if (got.flags !== want.flags)
      report($sformatf("frame_flags %h, want %h", got.flags, want.flags));
    if (got.data !== want.data)
      report($sformatf("data_byte %02h, want %02h", got.data, want.data));
    if (got.dlen !== want.dlen)
      report($sformatf("delivered_len %0d, want %0d", got.dlen, want.dlen));
    if (got.last !== want.last)
      report($sformatf("last %b, want %b", got.last, want.last));
  endtask
endclass

module preamble_length_xor_deframer_top_test;

  localparam int unsigned QuietLimit = 2000;

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       in_valid_i       = 1'b0;
  logic [7:0] rx_byte_i        = 8'h00;
  logic       out_ready_i      = 1'b0;
  logic       cfg_valid_i      = 1'b0;
  logic [6:0] cfg_copy_limit_i = 7'd0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] status_o;
  logic [3:0] command_o;
  logic [3:0] frame_flags_o;
  logic [7:0] data_byte_o;
  logic [6:0] delivered_len_o;
  logic       last_o;
  logic       cfg_ready_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles  = 0;

  logic [7:0] frame_q[$];
  deframe_scoreboard sb;

  preamble_length_xor_deframer_top uut (.*);

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin : take_results
    deframe_word_t got_word;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_word.status  = status_e'(status_o);
      got_word.command = command_o;
      got_word.flags   = frame_flags_o;
      got_word.data    = data_byte_o;
      got_word.dlen    = delivered_len_o;
      got_word.last    = last_o;
      sb.check_word(got_word);
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // any accepted word on any channel counts as progress
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b);
  endtask

  // valid is left high here; callers lower it once the burst is over
  task automatic send_queued();
    while (frame_q.size() > 0) send_byte(frame_q.pop_front());
  endtask

  function automatic void queue_frame(logic [7:0] hdr, logic [15:0] len, bit good_check);
    logic [7:0] chk;
    logic [7:0] b;
    int unsigned i;
    chk = XorSeed ^ PreambleByte ^ hdr ^ len[7:0] ^ len[15:8];
    frame_q.push_back(PreambleByte);
    frame_q.push_back(hdr);
    frame_q.push_back(len[7:0]);
    frame_q.push_back(len[15:8]);
    if (len > MaxPayload) return;
    for (i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      chk ^= b;
      frame_q.push_back(b);
    end
    if (!good_check) chk ^= 8'($urandom_range(1, 255));
    frame_q.push_back(chk);
  endfunction

  // mostly short payloads, now and then a full buffer
  function automatic logic [15:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'(MaxPayload);
    if (r < 25) return 16'($urandom_range(9, 63));
    if (r < 40) return 16'd0;
    return 16'($urandom_range(1, 8));
  endfunction

  task automatic write_copy_limit(logic [6:0] v);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i      <= 1'b1;
    cfg_copy_limit_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.copy_limit = v;
  endtask

  task automatic random_traffic(int unsigned budget);
    int unsigned counted;
    int unsigned r;
    int unsigned cut;
    logic [15:0] len;
    counted = 0;
    while (counted < budget) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // line noise while hunting, not counted
        repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        if (r < 16) begin
          if ($urandom_range(0, 1))
            len = {8'h00, 8'($urandom_range(65, 255))};
          else
            len = {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
          queue_frame(8'($urandom_range(0, 255)), len, 1'b1);
        end else begin
          queue_frame(8'($urandom_range(0, 255)), pick_length(), r >= 28);
          // truncated frame: the next frame's bytes get swallowed by this one
          if (r >= 28 && r < 36) begin
            cut = $urandom_range(1, frame_q.size() - 1);
            repeat (cut) void'(frame_q.pop_back());
          end
        end
        counted += frame_q.size();
      end
      send_queued();
    end
  endtask

  task automatic run_phase(int unsigned s_idle, int unsigned r_idle, logic [6:0] limit);
    in_valid_i <= 1'b0;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    write_copy_limit(limit);
    random_traffic(42);
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 15;
    recv_idle_pct = 60;

    // directed frames at the reset copy limit
    frame_q.push_back(8'h00);
    queue_frame(8'hA5, 16'd0, 1'b1);
    queue_frame(8'h3C, 16'd65, 1'b1);
    queue_frame(8'hFF, 16'hFFFF, 1'b1);
    queue_frame(8'h00, 16'd1, 1'b1);
    queue_frame(8'h5A, 16'd0, 1'b0);
    send_queued();

    run_phase(15, 60, 7'd0);
    run_phase(15, 60, 7'($urandom_range(2, 63)));
    run_phase(60, 15, 7'd64);
    run_phase(60, 15, 7'd1);
    run_phase(0, 0, 7'($urandom_range(2, 12)));
    run_phase(0, 0, 7'd64);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
